// ===== rtl/core/json_string_unescape_utf8_core_macros.svh =====
// ----------------------------------------------------------------------------
// JSON string unescaper assertion macros
// Shared shorthand for the concurrent checks in the core modules. The
// macros expect i_clk and i_rst_n in the scope where they are used.
// ----------------------------------------------------------------------------
`ifndef JSON_STRING_UNESCAPE_UTF8_CORE_MACROS_SVH
`define JSON_STRING_UNESCAPE_UTF8_CORE_MACROS_SVH

// Property checked on every clock edge outside of reset.
`define JSU_ASSERT(lbl, prop, msg) \
lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Condition in one cycle implies a consequence in the next cycle.
`define JSU_ASSERT_NEXT(lbl, ante, cons, msg) \
`JSU_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

// ===== rtl/core/jsu_pkg.sv =====
// ----------------------------------------------------------------------------
// JSON string unescaper package
// Shared types, codes and helper functions for the unescaper core.
// ----------------------------------------------------------------------------
package jsu_pkg;

    typedef logic [1:0] t_action;
    typedef logic [1:0] t_kind;
    typedef logic [3:0] t_err;

    // Input actions.
    localparam t_action ACT_START = 2'd0;
    localparam t_action ACT_NEXT  = 2'd1;
    localparam t_action ACT_END   = 2'd2;

    // Result kinds.
    localparam t_kind KIND_DATA     = 2'd0;
    localparam t_kind KIND_COMPLETE = 2'd1;
    localparam t_kind KIND_ERROR    = 2'd2;

    // Error numbers.
    localparam t_err ERR_NO_QUOTE     = 4'd0;
    localparam t_err ERR_CONTROL      = 4'd1;
    localparam t_err ERR_TRUNC_ESCAPE = 4'd2;
    localparam t_err ERR_BAD_UNICODE  = 4'd3;
    localparam t_err ERR_MISSING_LOW  = 4'd4;
    localparam t_err ERR_BAD_LOW      = 4'd5;
    localparam t_err ERR_LONE_LOW     = 4'd6;
    localparam t_err ERR_BAD_ESCAPE   = 4'd7;
    localparam t_err ERR_UNTERMINATED = 4'd8;

    // Character codes.
    localparam logic [7:0] CHAR_QUOTE     = 8'h22;
    localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
    localparam logic [7:0] CHAR_SLASH     = 8'h2F;
    localparam logic [7:0] CHAR_SPACE     = 8'h20;
    localparam logic [7:0] CHAR_B         = 8'h62;
    localparam logic [7:0] CHAR_F         = 8'h66;
    localparam logic [7:0] CHAR_N         = 8'h6E;
    localparam logic [7:0] CHAR_R         = 8'h72;
    localparam logic [7:0] CHAR_T         = 8'h74;
    localparam logic [7:0] CHAR_U         = 8'h75;

    // Surrogate ranges.
    localparam logic [15:0] HIGH_SURR_MIN = 16'hD800;
    localparam logic [15:0] HIGH_SURR_MAX = 16'hDBFF;
    localparam logic [15:0] LOW_SURR_MIN  = 16'hDC00;
    localparam logic [15:0] LOW_SURR_MAX  = 16'hDFFF;
    localparam logic [20:0] SUPPLEMENTARY_BASE = 21'h10000;

    localparam int MAX_RESULTS = 4;

    // All results of one input word: either 1 to 4 data bytes, or one
    // completion, or one error.
    typedef struct packed {
        logic [2:0]       count;
        t_kind            kind;
        t_err             code;
        logic [3:0][7:0]  bytes;
    } t_batch;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_hex;

    function automatic t_hex hex_value(input logic [7:0] c);
        t_hex r;
        r = '0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r.ok  = 1'b1;
            r.val = c[3:0];
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            r.ok  = 1'b1;
            r.val = 4'(c[3:0] + 4'd9);
        end
        return r;
    endfunction

    function automatic t_batch one_byte(input logic [7:0] b);
        t_batch r;
        r          = '0;
        r.count    = 3'd1;
        r.kind     = KIND_DATA;
        r.bytes[0] = b;
        return r;
    endfunction

    function automatic t_batch report(input t_kind k, input t_err code);
        t_batch r;
        r       = '0;
        r.count = 3'd1;
        r.kind  = k;
        r.code  = code;
        return r;
    endfunction

    function automatic t_batch utf8_encode(input logic [20:0] cp);
        t_batch r;
        r      = '0;
        r.kind = KIND_DATA;
        if (cp <= 21'h7F) begin
            r.count    = 3'd1;
            r.bytes[0] = cp[7:0];
        end else if (cp <= 21'h7FF) begin
            r.count    = 3'd2;
            r.bytes[0] = {3'b110, cp[10:6]};
            r.bytes[1] = {2'b10, cp[5:0]};
        end else if (cp <= 21'hFFFF) begin
            r.count    = 3'd3;
            r.bytes[0] = {4'b1110, cp[15:12]};
            r.bytes[1] = {2'b10, cp[11:6]};
            r.bytes[2] = {2'b10, cp[5:0]};
        end else begin
            r.count    = 3'd4;
            r.bytes[0] = {5'b11110, cp[20:18]};
            r.bytes[1] = {2'b10, cp[17:12]};
            r.bytes[2] = {2'b10, cp[11:6]};
            r.bytes[3] = {2'b10, cp[5:0]};
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/jsu_if.sv =====
// ----------------------------------------------------------------------------
// JSON string unescaper channels
// Valid/ready channels for the raw input bytes and the decoded results.
// ----------------------------------------------------------------------------
interface jsu_in_if;
    import jsu_pkg::*;

    logic       valid;
    logic       ready;
    t_action    action;
    logic [7:0] data_byte;

    modport source (output valid, output action, output data_byte, input ready);
    modport sink   (input valid, input action, input data_byte, output ready);
endinterface

interface jsu_out_if;
    import jsu_pkg::*;

    logic       valid;
    logic       ready;
    t_kind      kind;
    logic [7:0] out_byte;
    t_err       error_code;
    logic       last;

    modport source (output valid, output kind, output out_byte, output error_code,
                    output last, input ready);
    modport sink   (input valid, input kind, input out_byte, input error_code,
                    input last, output ready);
endinterface

// ===== rtl/core/jsu_decode.sv =====
// ----------------------------------------------------------------------------
// JSON string unescaper decoder
// Holds the escape state and turns one input word into its batch of results.
// ----------------------------------------------------------------------------
`include "json_string_unescape_utf8_core_macros.svh"

module jsu_decode (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  jsu_pkg::t_action i_action,
    input  logic [7:0]       i_byte,
    output jsu_pkg::t_batch  o_batch
);
    import jsu_pkg::*;

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_BODY = 3'd1;
    localparam logic [2:0] PH_ESC  = 3'd2;
    localparam logic [2:0] PH_HEX  = 3'd3;
    localparam logic [2:0] PH_LBS  = 3'd4;
    localparam logic [2:0] PH_LU   = 3'd5;
    localparam logic [2:0] PH_LHEX = 3'd6;
    localparam logic [2:0] PH_DONE = 3'd7;

    logic [2:0]  r_phase,     n_phase;
    logic [1:0]  r_hex_count, n_hex_count;
    logic [15:0] r_hex_accum, n_hex_accum;
    logic [9:0]  r_high_half, n_high_half;
    logic        r_bad_digit, n_bad_digit;

    t_hex        hv;
    logic [15:0] acc_shift;
    t_batch      utf_bmp;
    t_batch      utf_pair;
    t_batch      batch;

    assign hv        = hex_value(i_byte);
    assign acc_shift = {r_hex_accum[11:0], hv.val};
    assign utf_bmp   = utf8_encode({5'd0, acc_shift});
    // The low surrogate minus its base is just its low ten bits.
    assign utf_pair  = utf8_encode(SUPPLEMENTARY_BASE + 21'({r_high_half, acc_shift[9:0]}));

    always_comb begin
        n_phase     = r_phase;
        n_hex_count = r_hex_count;
        n_hex_accum = r_hex_accum;
        n_high_half = r_high_half;
        n_bad_digit = r_bad_digit;
        batch       = '0;

        if (i_step) begin
            if (i_action == ACT_START || (i_action == ACT_NEXT && r_phase == PH_IDLE)) begin
                n_hex_count = '0;
                n_hex_accum = '0;
                n_high_half = '0;
                n_bad_digit = 1'b0;
                if (i_byte != CHAR_QUOTE) begin
                    batch   = report(KIND_ERROR, ERR_NO_QUOTE);
                    n_phase = PH_DONE;
                end else begin
                    n_phase = PH_BODY;
                end
            end else if (i_action == ACT_NEXT) begin
                unique case (r_phase)
                    PH_BODY: begin
                        if (i_byte == CHAR_QUOTE) begin
                            batch   = report(KIND_COMPLETE, ERR_NO_QUOTE);
                            n_phase = PH_DONE;
                        end else if (i_byte < CHAR_SPACE) begin
                            batch   = report(KIND_ERROR, ERR_CONTROL);
                            n_phase = PH_DONE;
                        end else if (i_byte == CHAR_BACKSLASH) begin
                            n_phase = PH_ESC;
                        end else begin
                            batch = one_byte(i_byte);
                        end
                    end
                    PH_ESC: begin
                        n_phase = PH_BODY;
                        unique case (i_byte)
                            CHAR_QUOTE, CHAR_BACKSLASH, CHAR_SLASH: batch = one_byte(i_byte);
                            CHAR_B: batch = one_byte(8'h08);
                            CHAR_F: batch = one_byte(8'h0C);
                            CHAR_N: batch = one_byte(8'h0A);
                            CHAR_R: batch = one_byte(8'h0D);
                            CHAR_T: batch = one_byte(8'h09);
                            CHAR_U: begin
                                n_phase     = PH_HEX;
                                n_hex_count = '0;
                                n_hex_accum = '0;
                            end
                            default: begin
                                batch   = report(KIND_ERROR, ERR_BAD_ESCAPE);
                                n_phase = PH_DONE;
                            end
                        endcase
                    end
                    PH_HEX: begin
                        if (!hv.ok) begin
                            batch   = report(KIND_ERROR, ERR_BAD_UNICODE);
                            n_phase = PH_DONE;
                        end else begin
                            n_hex_accum = acc_shift;
                            n_hex_count = 2'(r_hex_count + 2'd1);
                            if (r_hex_count == 2'd3) begin
                                n_hex_count = '0;
                                if (acc_shift >= HIGH_SURR_MIN && acc_shift <= HIGH_SURR_MAX) begin
                                    n_high_half = acc_shift[9:0];
                                    n_phase     = PH_LBS;
                                end else if (acc_shift >= LOW_SURR_MIN &&
                                             acc_shift <= LOW_SURR_MAX) begin
                                    batch   = report(KIND_ERROR, ERR_LONE_LOW);
                                    n_phase = PH_DONE;
                                end else begin
                                    batch   = utf_bmp;
                                    n_phase = PH_BODY;
                                end
                            end
                        end
                    end
                    PH_LBS: begin
                        if (i_byte != CHAR_BACKSLASH) begin
                            batch   = report(KIND_ERROR, ERR_MISSING_LOW);
                            n_phase = PH_DONE;
                        end else begin
                            n_phase = PH_LU;
                        end
                    end
                    PH_LU: begin
                        if (i_byte != CHAR_U) begin
                            batch   = report(KIND_ERROR, ERR_MISSING_LOW);
                            n_phase = PH_DONE;
                        end else begin
                            n_phase     = PH_LHEX;
                            n_hex_count = '0;
                            n_hex_accum = '0;
                            n_bad_digit = 1'b0;
                        end
                    end
                    PH_LHEX: begin
                        // A bad digit is only reported once the quad is complete.
                        if (!hv.ok) begin
                            n_bad_digit = 1'b1;
                        end else begin
                            n_hex_accum = acc_shift;
                        end
                        n_hex_count = 2'(r_hex_count + 2'd1);
                        if (r_hex_count == 2'd3) begin
                            n_hex_count = '0;
                            if (r_bad_digit || !hv.ok || acc_shift < LOW_SURR_MIN ||
                                acc_shift > LOW_SURR_MAX) begin
                                batch   = report(KIND_ERROR, ERR_BAD_LOW);
                                n_phase = PH_DONE;
                            end else begin
                                batch   = utf_pair;
                                n_phase = PH_BODY;
                            end
                        end
                    end
                    default: ;
                endcase
            end else if (i_action == ACT_END) begin
                unique case (r_phase)
                    PH_IDLE: begin
                        batch   = report(KIND_ERROR, ERR_NO_QUOTE);
                        n_phase = PH_DONE;
                    end
                    PH_BODY: begin
                        batch   = report(KIND_ERROR, ERR_UNTERMINATED);
                        n_phase = PH_DONE;
                    end
                    PH_ESC: begin
                        batch   = report(KIND_ERROR, ERR_TRUNC_ESCAPE);
                        n_phase = PH_DONE;
                    end
                    PH_HEX: begin
                        batch   = report(KIND_ERROR, ERR_BAD_UNICODE);
                        n_phase = PH_DONE;
                    end
                    PH_LBS, PH_LU, PH_LHEX: begin
                        batch   = report(KIND_ERROR, ERR_MISSING_LOW);
                        n_phase = PH_DONE;
                    end
                    default: ;
                endcase
            end
        end
    end

    assign o_batch = batch;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_hex_count <= '0;
            r_hex_accum <= '0;
            r_high_half <= '0;
            r_bad_digit <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_hex_count <= n_hex_count;
            r_hex_accum <= n_hex_accum;
            r_high_half <= n_high_half;
            r_bad_digit <= n_bad_digit;
        end
    end

    `JSU_ASSERT_NEXT(a_error_ends, i_step && batch.count != 3'd0 && batch.kind == KIND_ERROR, r_phase == PH_DONE, "error did not end the string")
    `JSU_ASSERT_NEXT(a_complete_ends, i_step && batch.count != 3'd0 && batch.kind == KIND_COMPLETE, r_phase == PH_DONE, "completion did not end the string")
    `JSU_ASSERT_NEXT(a_pair_to_body, i_step && batch.count == 3'd4, r_phase == PH_BODY && r_hex_count == 2'd0, "surrogate pair did not return to the body")

endmodule

// ===== rtl/core/jsu_emit.sv =====
// ----------------------------------------------------------------------------
// JSON string unescaper result buffer
// Holds one batch of results and hands them out one word per cycle while the receiver is ready.
// ----------------------------------------------------------------------------
`include "json_string_unescape_utf8_core_macros.svh"

module jsu_emit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_load,
    input  jsu_pkg::t_batch i_batch,
    output logic            o_can_load,
    output logic            o_valid,
    input  logic            i_ready,
    output jsu_pkg::t_kind  o_kind,
    output logic [7:0]      o_byte,
    output jsu_pkg::t_err   o_code,
    output logic            o_last
);
    import jsu_pkg::*;

    logic            r_valid;
    logic [1:0]      r_idx;
    logic [1:0]      r_last_idx;
    t_kind           r_kind;
    t_err            r_code;
    logic [3:0][7:0] r_bytes;
    logic            handshake;

    assign o_valid    = r_valid;
    assign o_kind     = r_kind;
    assign o_code     = r_code;
    assign o_byte     = r_bytes[r_idx];
    assign o_last     = (r_idx == r_last_idx);
    assign handshake  = r_valid && i_ready;
    // A new batch may enter as the last word of the current one leaves.
    assign o_can_load = !r_valid || (i_ready && o_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_idx   <= '0;
        end else if (handshake) begin
            if (o_last) begin
                r_valid <= 1'b0;
            end else begin
                r_idx <= 2'(r_idx + 2'd1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_last_idx <= 2'(i_batch.count - 3'd1);
            r_kind     <= i_batch.kind;
            r_code     <= i_batch.code;
            r_bytes    <= i_batch.bytes;
        end
    end

    `JSU_ASSERT(a_load_allowed, i_load |-> o_can_load, "batch loaded over pending results")
    `JSU_ASSERT(a_single_report, r_valid && r_kind != KIND_DATA |-> r_last_idx == 2'd0, "status result is not alone in its batch")
    `JSU_ASSERT_NEXT(a_advance, handshake && !o_last, r_valid && r_idx == 2'($past(r_idx) + 2'd1), "batch did not advance to its next word")

endmodule

// ===== rtl/core/json_string_unescape_utf8_core.sv =====
// ----------------------------------------------------------------------------
// JSON string unescaper core
// Decodes the bytes of one quoted JSON string into UTF-8. The first word must
// carry the opening quote; plain bytes pass through, escapes are resolved and
// \u escapes (with surrogate pairs) become 1 to 4 UTF-8 bytes. The closing
// quote gives a completion word, faults give one error word with its number,
// and the final word caused by each input word has last set. Plain text streams
// at one byte per clock while the receiver is ready; a word that yields several
// results (up to four for a surrogate pair) holds the output register until all
// are taken, which stalls the input. Each accepted input word is registered,
// then decoded and loaded into the output register.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_core (
    input  logic  i_clk,
    input  logic  i_rst_n,
    jsu_in_if.sink    i_in,
    jsu_out_if.source o_out
);
    import jsu_pkg::*;

    logic       r_in_valid;
    t_action    r_action;
    logic [7:0] r_byte;
    logic       can_load;
    logic       advance;
    t_batch     batch;

    assign advance    = r_in_valid && can_load;
    assign i_in.ready = !r_in_valid || can_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_action <= i_in.action;
            r_byte   <= i_in.data_byte;
        end
    end

    jsu_decode u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_action (r_action),
        .i_byte   (r_byte),
        .o_batch  (batch)
    );

    jsu_emit u_emit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (advance && batch.count != 3'd0),
        .i_batch    (batch),
        .o_can_load (can_load),
        .o_valid    (o_out.valid),
        .i_ready    (o_out.ready),
        .o_kind     (o_out.kind),
        .o_byte     (o_out.out_byte),
        .o_code     (o_out.error_code),
        .o_last     (o_out.last)
    );

endmodule

// ===== sim/jsu_decode_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// JSON string unescaper checker
// Watches both channels of the unescaper core. Every accepted input word is
// run through a local decoder model, which queues the UTF-8 bytes, the
// completion or the error it should produce. Every accepted output word is
// compared field by field with the oldest queued entry.
// ----------------------------------------------------------------------------
module jsu_decode_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    jsu_in_if    i_in,
    jsu_out_if   i_out,
    output int   o_fail_count,
    output int   o_pending
);
    import jsu_pkg::*;

    localparam t_err NO_ERROR = '0;

    typedef enum logic [3:0] {
        DEC_IDLE,
        DEC_BODY,
        DEC_ESCAPE,
        DEC_HIGH_HEX,
        DEC_LOW_BSLASH,
        DEC_LOW_U,
        DEC_LOW_HEX,
        DEC_DONE
    } t_dec_phase;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] out_byte;
        t_err       error_code;
        logic       last;
    } t_result;

    t_result     decoded_q[$];
    t_dec_phase  phase;
    logic [2:0]  quad_pos;
    logic [15:0] quad_val;
    logic [9:0]  high_bits;
    logic        low_digit_bad;
    int          mismatch_count;

    function automatic void push_result(input t_kind k, input logic [7:0] b, input t_err code);
        t_result r;
        r.kind       = k;
        r.out_byte   = b;
        r.error_code = code;
        r.last       = 1'b0;
        decoded_q.insert(decoded_q.size(), r);
    endfunction

    function automatic void raise_error(input t_err code);
        phase = DEC_DONE;
        push_result(KIND_ERROR, 8'h00, code);
    endfunction

    function automatic void push_utf8(input logic [20:0] cp);
        if (cp < 21'h80) begin
            push_result(KIND_DATA, cp[7:0], NO_ERROR);
        end else if (cp < 21'h800) begin
            push_result(KIND_DATA, {3'b110, cp[10:6]}, NO_ERROR);
            push_result(KIND_DATA, {2'b10, cp[5:0]}, NO_ERROR);
        end else if (cp < 21'h10000) begin
            push_result(KIND_DATA, {4'b1110, cp[15:12]}, NO_ERROR);
            push_result(KIND_DATA, {2'b10, cp[11:6]}, NO_ERROR);
            push_result(KIND_DATA, {2'b10, cp[5:0]}, NO_ERROR);
        end else begin
            push_result(KIND_DATA, {5'b11110, cp[20:18]}, NO_ERROR);
            push_result(KIND_DATA, {2'b10, cp[17:12]}, NO_ERROR);
            push_result(KIND_DATA, {2'b10, cp[11:6]}, NO_ERROR);
            push_result(KIND_DATA, {2'b10, cp[5:0]}, NO_ERROR);
        end
    endfunction

    // Top bit flags a valid hex digit, the low nibble holds its value.
    function automatic logic [4:0] digit_of(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) begin
            return {1'b1, c[3:0]};
        end
        if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            return {1'b1, 4'(c[3:0] + 4'd9)};
        end
        return 5'd0;
    endfunction

    function automatic void take_byte(input logic [7:0] c);
        logic [4:0] d;
        d = digit_of(c);
        case (phase)
            DEC_BODY: begin
                if (c == CHAR_QUOTE) begin
                    phase = DEC_DONE;
                    push_result(KIND_COMPLETE, 8'h00, NO_ERROR);
                end else if (c < CHAR_SPACE) begin
                    raise_error(ERR_CONTROL);
                end else if (c == CHAR_BACKSLASH) begin
                    phase = DEC_ESCAPE;
                end else begin
                    push_result(KIND_DATA, c, NO_ERROR);
                end
            end
            DEC_ESCAPE: begin
                phase = DEC_BODY;
                case (c)
                    CHAR_QUOTE, CHAR_BACKSLASH, CHAR_SLASH: push_result(KIND_DATA, c, NO_ERROR);
                    CHAR_B: push_result(KIND_DATA, 8'h08, NO_ERROR);
                    CHAR_F: push_result(KIND_DATA, 8'h0C, NO_ERROR);
                    CHAR_N: push_result(KIND_DATA, 8'h0A, NO_ERROR);
                    CHAR_R: push_result(KIND_DATA, 8'h0D, NO_ERROR);
                    CHAR_T: push_result(KIND_DATA, 8'h09, NO_ERROR);
                    CHAR_U: begin
                        phase    = DEC_HIGH_HEX;
                        quad_pos = '0;
                        quad_val = '0;
                    end
                    default: raise_error(ERR_BAD_ESCAPE);
                endcase
            end
            DEC_HIGH_HEX: begin
                if (!d[4]) begin
                    raise_error(ERR_BAD_UNICODE);
                end else begin
                    quad_val = {quad_val[11:0], d[3:0]};
                    quad_pos = quad_pos + 3'd1;
                    if (quad_pos == 3'd4) begin
                        quad_pos = '0;
                        if (quad_val >= HIGH_SURR_MIN && quad_val <= HIGH_SURR_MAX) begin
                            // The base of the high range has its low ten bits clear.
                            high_bits = quad_val[9:0];
                            phase     = DEC_LOW_BSLASH;
                        end else if (quad_val >= LOW_SURR_MIN && quad_val <= LOW_SURR_MAX) begin
                            raise_error(ERR_LONE_LOW);
                        end else begin
                            phase = DEC_BODY;
                            push_utf8({5'd0, quad_val});
                        end
                    end
                end
            end
            DEC_LOW_BSLASH: begin
                if (c != CHAR_BACKSLASH) begin
                    raise_error(ERR_MISSING_LOW);
                end else begin
                    phase = DEC_LOW_U;
                end
            end
            DEC_LOW_U: begin
                if (c != CHAR_U) begin
                    raise_error(ERR_MISSING_LOW);
                end else begin
                    phase         = DEC_LOW_HEX;
                    quad_pos      = '0;
                    quad_val      = '0;
                    low_digit_bad = 1'b0;
                end
            end
            DEC_LOW_HEX: begin
                // A bad digit still uses up its position; it is reported only
                // once the quad is complete.
                if (!d[4]) begin
                    low_digit_bad = 1'b1;
                end else begin
                    quad_val = {quad_val[11:0], d[3:0]};
                end
                quad_pos = quad_pos + 3'd1;
                if (quad_pos == 3'd4) begin
                    quad_pos = '0;
                    if (low_digit_bad || quad_val < LOW_SURR_MIN || quad_val > LOW_SURR_MAX) begin
                        raise_error(ERR_BAD_LOW);
                    end else begin
                        phase = DEC_BODY;
                        push_utf8(SUPPLEMENTARY_BASE + {1'b0, high_bits, quad_val[9:0]});
                    end
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void predict_word(input t_action act, input logic [7:0] c);
        int      queued;
        t_result r;
        queued = decoded_q.size();
        if (act == ACT_START || (act == ACT_NEXT && phase == DEC_IDLE)) begin
            quad_pos      = '0;
            quad_val      = '0;
            high_bits     = '0;
            low_digit_bad = 1'b0;
            if (c != CHAR_QUOTE) begin
                raise_error(ERR_NO_QUOTE);
            end else begin
                phase = DEC_BODY;
            end
        end else if (act == ACT_NEXT) begin
            take_byte(c);
        end else if (act == ACT_END) begin
            case (phase)
                DEC_IDLE:     raise_error(ERR_NO_QUOTE);
                DEC_BODY:     raise_error(ERR_UNTERMINATED);
                DEC_ESCAPE:   raise_error(ERR_TRUNC_ESCAPE);
                DEC_HIGH_HEX: raise_error(ERR_BAD_UNICODE);
                DEC_LOW_BSLASH, DEC_LOW_U, DEC_LOW_HEX: raise_error(ERR_MISSING_LOW);
                default: ;
            endcase
        end
        if (decoded_q.size() > queued) begin
            r      = decoded_q.pop_back();
            r.last = 1'b1;
            decoded_q.insert(decoded_q.size(), r);
        end
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            phase          = DEC_IDLE;
            quad_pos       = '0;
            quad_val       = '0;
            high_bits      = '0;
            low_digit_bad  = 1'b0;
            mismatch_count = 0;
            decoded_q.delete();
        end else begin
            // An input word cannot produce a result at the edge it is taken,
            // so the compare may safely run first.
            if (i_out.valid && i_out.ready) begin
                if (decoded_q.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected word, expected none, %s%0d byte=0x%0h %s%0d last=%b",
                             $time, "actual kind=", i_out.kind, i_out.out_byte, "code=",
                             i_out.error_code, i_out.last);
                end else begin
                    want = decoded_q.pop_front();
                    check_field("kind", 8'(want.kind), 8'(i_out.kind));
                    check_field("out_byte", want.out_byte, i_out.out_byte);
                    check_field("error_code", 8'(want.error_code), 8'(i_out.error_code));
                    check_field("last", 8'(want.last), 8'(i_out.last));
                end
            end
            if (i_in.valid && i_in.ready) begin
                predict_word(i_in.action, i_in.data_byte);
            end
        end
        o_fail_count <= mismatch_count;
        o_pending    <= decoded_q.size();
    end

endmodule

// ===== sim/tb_json_string_unescape_utf8_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// JSON string unescaper testbench
// Feeds the core quoted strings: a short directed run over the edge bytes,
// escapes, a maximal surrogate pair and the done state, then random strings,
// about half of them well formed and the rest carrying one injected fault.
// The sender works in bursts, the receiver stalls in changing patterns, and
// the checker beside the core predicts and compares every output word.
// ----------------------------------------------------------------------------
module tb_json_string_unescape_utf8_core;
    import jsu_pkg::*;

    // The fourth action code has no meaning; the core must take and drop it.
    localparam t_action ACT_IGNORED = 2'd3;

    localparam int RANDOM_WORDS = 170;
    localparam int DRAIN_CYCLES = 12;
    localparam int LIMIT_CYCLES = 200000;

    typedef enum {
        FLT_NONE,
        FLT_CONTROL,
        FLT_BAD_ESCAPE,
        FLT_BAD_HIGH_DIGIT,
        FLT_LONE_LOW,
        FLT_NO_BACKSLASH,
        FLT_NO_U,
        FLT_BAD_LOW_DIGIT,
        FLT_BAD_LOW_DIGIT_END,
        FLT_LOW_RANGE,
        FLT_END_BODY,
        FLT_END_ESCAPE,
        FLT_END_HIGH,
        FLT_END_LOW,
        FLT_RESTART
    } t_fault;

    typedef enum {SINK_OPEN, SINK_BUSY, SINK_PERIODIC, SINK_SLOW} t_sink_mode;

    logic       i_clk;
    logic       i_rst_n;
    int         fail_count;
    int         pending;
    int         words_sent;
    int         burst_left;
    int         cycle_count = 0;
    logic       timed_out;
    t_sink_mode sink_mode   = SINK_OPEN;
    int         sink_cycles = 0;
    logic [1:0] sink_phase  = '0;
    logic [7:0] simple_escapes [8] = '{CHAR_QUOTE, CHAR_BACKSLASH, CHAR_SLASH, CHAR_B,
                                       CHAR_F, CHAR_N, CHAR_R, CHAR_T};

    jsu_in_if  u_in_if ();
    jsu_out_if u_out_if ();

    json_string_unescape_utf8_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (u_in_if),
        .o_out   (u_out_if)
    );

    jsu_decode_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (u_in_if),
        .i_out        (u_out_if),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // Receiver: picks a new random stall pattern whenever the current one runs out.
    always @(posedge i_clk) begin
        if (sink_cycles == 0) begin
            sink_mode   <= t_sink_mode'($urandom_range(0, 3));
            sink_cycles <= $urandom_range(20, 80);
        end else begin
            sink_cycles <= sink_cycles - 1;
        end
        sink_phase <= sink_phase + 2'd1;
        case (sink_mode)
            SINK_OPEN:     u_out_if.ready <= 1'b1;
            SINK_BUSY:     u_out_if.ready <= ($urandom_range(0, 9) < 7);
            SINK_PERIODIC: u_out_if.ready <= (sink_phase == 2'd0);
            default:       u_out_if.ready <= ($urandom_range(0, 9) < 3);
        endcase
    end

    function automatic logic [7:0] any_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_word(input t_action act, input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                u_in_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        u_in_if.valid     <= 1'b1;
        u_in_if.action    <= act;
        u_in_if.data_byte <= b;
        @(posedge i_clk);
        while (!u_in_if.ready) @(posedge i_clk);
        burst_left--;
        if (act != ACT_IGNORED) begin
            words_sent++;
        end
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 4'd10) begin
            return 8'h30 + {4'd0, v};
        end
        return (($urandom_range(0, 1) != 0) ? 8'h61 : 8'h41) + {4'd0, v} - 8'd10;
    endfunction

    function automatic logic [7:0] non_hex_byte();
        logic [7:0] c;
        do begin
            c = any_byte();
        end while ((c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
                   (c >= 8'h61 && c <= 8'h66));
        return c;
    endfunction

    function automatic logic [7:0] non_escape_byte();
        logic [7:0] c;
        do begin
            c = any_byte();
        end while (c == CHAR_QUOTE || c == CHAR_BACKSLASH || c == CHAR_SLASH || c == CHAR_B ||
                   c == CHAR_F || c == CHAR_N || c == CHAR_R || c == CHAR_T || c == CHAR_U);
        return c;
    endfunction

    function automatic logic [7:0] plain_byte();
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(CHAR_SPACE, 8'hFF));
        end while (c == CHAR_QUOTE || c == CHAR_BACKSLASH);
        return c;
    endfunction

    // A code point outside the surrogate ranges, spread over the three
    // encoded lengths.
    function automatic logic [15:0] bmp_value();
        logic [15:0] v;
        case ($urandom_range(0, 2))
            0: v = 16'($urandom_range(0, 16'h7F));
            1: v = 16'($urandom_range(16'h80, 16'h7FF));
            default: begin
                do begin
                    v = 16'($urandom_range(16'h800, 16'hFFFF));
                end while (v >= HIGH_SURR_MIN && v <= LOW_SURR_MAX);
            end
        endcase
        return v;
    endfunction

    task automatic send_escape_u(input logic [15:0] v);
        send_word(ACT_NEXT, CHAR_BACKSLASH);
        send_word(ACT_NEXT, CHAR_U);
        for (int i = 3; i >= 0; i--) begin
            send_word(ACT_NEXT, hex_char(v[i*4 +: 4]));
        end
    endtask

    task automatic send_high();
        send_escape_u(16'($urandom_range(HIGH_SURR_MIN, HIGH_SURR_MAX)));
    endtask

    task automatic send_segment();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
            send_word(ACT_NEXT, plain_byte());
        end else if (pick < 65) begin
            send_word(ACT_NEXT, CHAR_BACKSLASH);
            send_word(ACT_NEXT, simple_escapes[3'($urandom_range(0, 7))]);
        end else if (pick < 80) begin
            send_escape_u(bmp_value());
        end else if (pick < 92) begin
            send_high();
            send_escape_u(16'($urandom_range(LOW_SURR_MIN, LOW_SURR_MAX)));
        end else begin
            send_word(ACT_IGNORED, any_byte());
        end
    endtask

    task automatic send_fault(input t_fault f);
        int          k;
        int          bad_pos;
        logic [7:0]  c;
        logic [15:0] v;
        v = 16'($urandom_range(0, 16'hFFFF));
        case (f)
            FLT_CONTROL: send_word(ACT_NEXT, 8'($urandom_range(0, CHAR_SPACE - 1)));
            FLT_BAD_ESCAPE: begin
                send_word(ACT_NEXT, CHAR_BACKSLASH);
                send_word(ACT_NEXT, non_escape_byte());
            end
            FLT_BAD_HIGH_DIGIT: begin
                send_word(ACT_NEXT, CHAR_BACKSLASH);
                send_word(ACT_NEXT, CHAR_U);
                k = $urandom_range(0, 3);
                for (int i = 0; i < k; i++) begin
                    send_word(ACT_NEXT, hex_char(v[i*4 +: 4]));
                end
                send_word(ACT_NEXT, non_hex_byte());
            end
            FLT_LONE_LOW: send_escape_u(16'($urandom_range(LOW_SURR_MIN, LOW_SURR_MAX)));
            FLT_NO_BACKSLASH: begin
                send_high();
                do begin
                    c = any_byte();
                end while (c == CHAR_BACKSLASH);
                send_word(ACT_NEXT, c);
            end
            FLT_NO_U: begin
                send_high();
                send_word(ACT_NEXT, CHAR_BACKSLASH);
                do begin
                    c = any_byte();
                end while (c == CHAR_U);
                send_word(ACT_NEXT, c);
            end
            FLT_BAD_LOW_DIGIT, FLT_BAD_LOW_DIGIT_END: begin
                send_high();
                send_word(ACT_NEXT, CHAR_BACKSLASH);
                send_word(ACT_NEXT, CHAR_U);
                k       = (f == FLT_BAD_LOW_DIGIT) ? 4 : $urandom_range(1, 3);
                bad_pos = $urandom_range(0, k - 1);
                for (int i = 0; i < k; i++) begin
                    send_word(ACT_NEXT, (i == bad_pos) ? non_hex_byte() : hex_char(v[i*4 +: 4]));
                end
                if (f == FLT_BAD_LOW_DIGIT_END) begin
                    send_word(ACT_END, any_byte());
                end
            end
            FLT_LOW_RANGE: begin
                send_high();
                while (v >= LOW_SURR_MIN && v <= LOW_SURR_MAX) begin
                    v = 16'($urandom_range(0, 16'hFFFF));
                end
                send_escape_u(v);
            end
            FLT_END_BODY: send_word(ACT_END, any_byte());
            FLT_END_ESCAPE: begin
                send_word(ACT_NEXT, CHAR_BACKSLASH);
                send_word(ACT_END, any_byte());
            end
            FLT_END_HIGH: begin
                send_word(ACT_NEXT, CHAR_BACKSLASH);
                send_word(ACT_NEXT, CHAR_U);
                k = $urandom_range(0, 3);
                for (int i = 0; i < k; i++) begin
                    send_word(ACT_NEXT, hex_char(v[i*4 +: 4]));
                end
                send_word(ACT_END, any_byte());
            end
            FLT_END_LOW: begin
                // Stop while waiting for the backslash, the u, or inside the quad.
                send_high();
                k = $urandom_range(0, 5);
                if (k >= 1) send_word(ACT_NEXT, CHAR_BACKSLASH);
                if (k >= 2) send_word(ACT_NEXT, CHAR_U);
                for (int i = 0; i < k - 2; i++) begin
                    send_word(ACT_NEXT, hex_char(v[i*4 +: 4]));
                end
                send_word(ACT_END, any_byte());
            end
            FLT_RESTART: begin
                send_word(ACT_START, ($urandom_range(0, 1) != 0) ? CHAR_QUOTE : any_byte());
            end
            default: ;
        endcase
    endtask

    task automatic send_string(input t_fault f);
        int segs;
        int at;
        segs = $urandom_range(0, 6);
        at   = $urandom_range(0, segs);
        send_word(ACT_START, CHAR_QUOTE);
        for (int i = 0; i <= segs; i++) begin
            if (i == at && f != FLT_NONE) begin
                send_fault(f);
                if (f != FLT_RESTART) begin
                    // Sometimes poke the core once more after the error.
                    if ($urandom_range(0, 3) == 0) begin
                        send_word(($urandom_range(0, 1) != 0) ? ACT_NEXT : ACT_END,
                                  any_byte());
                    end
                    return;
                end
            end
            if (i < segs) begin
                send_segment();
            end
        end
        send_word(ACT_NEXT, CHAR_QUOTE);
        if ($urandom_range(0, 7) == 0) begin
            send_word(($urandom_range(0, 1) != 0) ? ACT_NEXT : ACT_END, any_byte());
        end
    endtask

    initial begin
        u_in_if.valid     <= 1'b0;
        u_in_if.action    <= ACT_START;
        u_in_if.data_byte <= 8'h00;
        i_rst_n           <= 1'b0;
        timed_out  = 1'b0;
        burst_left = 0;
        words_sent = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        fork
            begin
                // Directed run: the unused action and a word in the idle state
                // first, since idle is only reachable straight after reset.
                send_word(ACT_IGNORED, 8'hFF);
                if ($urandom_range(0, 1) != 0) begin
                    send_word(ACT_END, 8'h00);
                    send_word(ACT_START, CHAR_QUOTE);
                end else begin
                    send_word(ACT_NEXT, CHAR_QUOTE);
                end
                send_word(ACT_NEXT, CHAR_SPACE);
                send_word(ACT_NEXT, 8'hFF);
                send_word(ACT_NEXT, CHAR_BACKSLASH);
                send_word(ACT_NEXT, CHAR_T);
                send_escape_u(HIGH_SURR_MAX);
                send_escape_u(LOW_SURR_MAX);
                send_word(ACT_NEXT, CHAR_QUOTE);
                send_word(ACT_NEXT, 8'h41);
                send_word(ACT_END, 8'h00);
                send_word(ACT_START, 8'h00);

                words_sent = 0;
                while (words_sent < RANDOM_WORDS) begin
                    if ($urandom_range(0, 99) < 45) begin
                        send_string(FLT_NONE);
                    end else begin
                        send_string(t_fault'($urandom_range(int'(FLT_CONTROL),
                                                            int'(FLT_RESTART))));
                    end
                end
                u_in_if.valid <= 1'b0;
                @(posedge i_clk);
                while (pending != 0) @(posedge i_clk);
                repeat (DRAIN_CYCLES) @(posedge i_clk);
            end
            begin
                wait (cycle_count >= LIMIT_CYCLES);
                timed_out = 1'b1;
            end
        join_any
        if (!timed_out && fail_count == 0) begin
            $display("** json_string_unescape_utf8_core: PASSED **");
        end else begin
            $display("** json_string_unescape_utf8_core: FAILED **");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/jsu_pkg.sv
rtl/core/jsu_if.sv
rtl/core/jsu_decode.sv
rtl/core/jsu_emit.sv
rtl/core/json_string_unescape_utf8_core.sv
sim/jsu_decode_checker.sv
sim/tb_json_string_unescape_utf8_core.sv
